FILE: src/lwcs_pkg.sv
// ----------------------------------------------------------------------------
// lwcs_pkg
// Shared types, widths and constants for the laser window collision stop.
// ----------------------------------------------------------------------------
package lwcs_pkg;

    localparam int MAX_BEAMS_DEF    = 1024;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam int DIVN_W = 42;   // signed dividend width
    localparam int DIVD_W = 24;   // unsigned divisor width
    localparam int CORD_W = 54;   // CORDIC x/y datapath width
    localparam int ANG_W  = 23;   // angle width, microradians
    localparam int IDX_W  = 13;   // signed beam index width

    localparam logic [ANG_W-1:0] HALF_DEFAULT = ANG_W'(785398);
    localparam logic [15:0]      RANGE_NONE   = 16'hFFFF;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_STOP  = 2'd1;
    localparam logic [1:0] REG_FIRST = 2'd2;
    localparam logic [1:0] REG_STEP  = 2'd3;

    typedef struct packed {
        logic [15:0]             gain;
        logic [15:0]             stop_dist;
        logic signed [ANG_W-1:0] first_angle;
        logic [15:0]             step;
    } t_cfg;

    typedef struct packed {
        logic               is_sample;
        logic               fast;       // begin with speed above 10 mm/s
        logic signed [15:0] speed;
        logic signed [15:0] turn;
        logic [15:0]        range;
        logic               invalid;
        logic               last;
    } t_item;

    typedef struct packed {
        logic        stop;
        logic [15:0] min_range;
    } t_result;

    // arctangent of 2^-i in whole microradians
    function automatic logic [19:0] f_atan(input logic [4:0] i);
        logic [19:0] r;
        case (i)
            5'd0:    r = 20'd785398;
            5'd1:    r = 20'd463648;
            5'd2:    r = 20'd244979;
            5'd3:    r = 20'd124355;
            5'd4:    r = 20'd62419;
            5'd5:    r = 20'd31240;
            5'd6:    r = 20'd15624;
            5'd7:    r = 20'd7812;
            5'd8:    r = 20'd3906;
            5'd9:    r = 20'd1953;
            5'd10:   r = 20'd977;
            5'd11:   r = 20'd488;
            5'd12:   r = 20'd244;
            5'd13:   r = 20'd122;
            5'd14:   r = 20'd61;
            5'd15:   r = 20'd31;
            5'd16:   r = 20'd15;
            5'd17:   r = 20'd8;
            5'd18:   r = 20'd4;
            5'd19:   r = 20'd2;
            5'd20:   r = 20'd1;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/lwcs_div.sv
// ----------------------------------------------------------------------------
// lwcs_div
// Serial restoring divider, signed dividend by positive divisor, one quotient
// bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lwcs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [lwcs_pkg::DIVN_W-1:0] i_dividend,
    input  logic [lwcs_pkg::DIVD_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic signed [lwcs_pkg::DIVN_W-1:0] o_quotient
);
    import lwcs_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W);

    logic              r_busy, r_done, r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVN_W-1:0] r_a;
    logic [DIVD_W-1:0] r_rem, r_d;
    logic [DIVD_W-1:0] w_trial;
    logic              w_ge;

    assign w_trial = {r_rem[DIVD_W-2:0], r_a[DIVN_W-1]};
    assign w_ge    = (w_trial >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(DIVN_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIVN_W-1];
            r_a   <= i_dividend[DIVN_W-1] ? DIVN_W'(-i_dividend) : i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - r_d) : w_trial;
            r_a   <= {r_a[DIVN_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_a) : $signed(r_a);

endmodule

FILE: src/lwcs_front.sv
// ----------------------------------------------------------------------------
// lwcs_front
// Accepts input items, tags begin/sample and the speed test, and holds them
// in a two entry queue for the back end.
// ----------------------------------------------------------------------------
module lwcs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_cmd,
    input  logic signed [15:0] i_speed,
    input  logic signed [15:0] i_turn,
    input  logic [15:0]        i_range,
    input  logic               i_invalid,
    input  logic               i_last,
    output logic               o_full,
    output logic               o_avail,
    output lwcs_pkg::t_item    o_item,
    input  logic               i_take
);
    import lwcs_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_in, w_out;
    t_item      w_new;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_avail;

    always_comb begin
        w_new.is_sample = i_cmd;
        w_new.fast      = (i_speed > 16'sd10);
        w_new.speed     = i_speed;
        w_new.turn      = i_turn;
        w_new.range     = i_range;
        w_new.invalid   = i_invalid;
        w_new.last      = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in)  r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wp] <= w_new;
    end

    assign o_item = r_q[r_rp];

endmodule

FILE: src/lwcs_back.sv
// ----------------------------------------------------------------------------
// lwcs_back
// Executes queued items: window setup on begin (multiply, divide, CORDIC for a fast
// begin, then two index divides for every begin) and minimum tracking per range sample.
// ----------------------------------------------------------------------------
module lwcs_back #(
    parameter int MAX_BEAMS    = lwcs_pkg::MAX_BEAMS_DEF,
    parameter int CORDIC_STEPS = lwcs_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lwcs_pkg::t_cfg    i_cfg,
    input  logic              i_avail,
    input  lwcs_pkg::t_item   i_item,
    output logic              o_take,
    output logic              o_res_valid,
    output lwcs_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import lwcs_pkg::*;

    localparam int CW     = $clog2(MAX_BEAMS + 1);
    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_QST   = 4'd2;
    localparam logic [3:0] S_QDIV  = 4'd3;
    localparam logic [3:0] S_CORD  = 4'd4;
    localparam logic [3:0] S_LOST  = 4'd5;
    localparam logic [3:0] S_LODIV = 4'd6;
    localparam logic [3:0] S_HIST  = 4'd7;
    localparam logic [3:0] S_HIDIV = 4'd8;

    logic [3:0]               r_state;
    logic signed [15:0]       r_v;
    logic signed [32:0]       r_prod;
    logic signed [DIVN_W-1:0] r_num;
    logic signed [CORD_W-1:0] r_xa, r_ya;
    logic signed [ANG_W-1:0]  r_z;
    logic [4:0]               r_it;
    logic signed [IDX_W-1:0]  r_first, r_last;
    logic [CW-1:0]            r_ctr;
    logic [15:0]              r_min;
    logic                     r_open;

    logic                     w_start, w_done;
    logic signed [DIVN_W-1:0] w_dvd, w_quot;
    logic [DIVD_W-1:0]        w_dvs;
    logic signed [43:0]       w_num_full;
    logic signed [10:0]       c_k;
    logic signed [24:0]       w_lo, w_hi;
    logic signed [DIVN_W-1:0] w_y;
    logic signed [CORD_W-1:0] w_dx, w_dy;
    logic signed [ANG_W-1:0]  w_at;
    logic signed [IDX_W-1:0]  w_sat;
    logic signed [IDX_W-1:0]  w_idx;
    logic                     w_hit;
    logic [15:0]              w_min;
    logic                     w_sample_go;

    assign c_k        = 11'sd1000;
    assign w_num_full = r_prod * c_k;

    // window edges relative to beam zero
    assign w_lo = -{{2{r_z[ANG_W-1]}}, r_z} - {{2{i_cfg.first_angle[ANG_W-1]}}, i_cfg.first_angle};
    assign w_hi =  {{2{r_z[ANG_W-1]}}, r_z} - {{2{i_cfg.first_angle[ANG_W-1]}}, i_cfg.first_angle};

    always_comb begin
        w_dvd = r_num;
        w_dvs = {1'b0, r_v[14:0], 8'd0};
        if (r_state == S_LOST || r_state == S_HIST) begin
            w_dvd = (r_state == S_LOST) ? DIVN_W'(w_lo) : DIVN_W'(w_hi);
            w_dvs = (i_cfg.step == 16'd0) ? DIVD_W'(1) : DIVD_W'(i_cfg.step);
        end
    end
    assign w_start = (r_state == S_QST) || (r_state == S_LOST) || (r_state == S_HIST);

    lwcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        if (w_quot < -DIVN_W'(4096))     w_sat = IDX_W'(-4096);
        else if (w_quot > DIVN_W'(4095)) w_sat = IDX_W'(4095);
        else                             w_sat = w_quot[IDX_W-1:0];
    end

    // CORDIC vectoring step
    assign w_y  = w_quot + DIVN_W'(200);
    assign w_dx = r_ya >>> r_it;
    assign w_dy = r_xa >>> r_it;
    assign w_at = $signed({3'b000, f_atan(r_it)});

    // sample path
    assign w_idx = $signed({{(IDX_W-CW){1'b0}}, r_ctr});
    assign w_hit = (r_ctr < CW'(MAX_BEAMS)) && !i_item.invalid &&
                   (w_idx >= r_first) && (w_idx <= r_last) && (i_item.range < r_min);
    assign w_min = w_hit ? i_item.range : r_min;

    assign w_sample_go = (r_state == S_IDLE) && i_avail && i_item.is_sample &&
                         (!r_open || !i_item.last || i_res_ready);
    assign o_take      = w_sample_go || ((r_state == S_IDLE) && i_avail && !i_item.is_sample);
    assign o_res_valid = w_sample_go && r_open && i_item.last;
    assign o_res.stop      = (w_min < i_cfg.stop_dist);
    assign o_res.min_range = w_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= 1'b0;
            r_ctr   <= '0;
            r_min   <= RANGE_NONE;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_sample_go && r_open) begin
                        r_min <= w_min;
                        if (r_ctr < CW'(MAX_BEAMS)) r_ctr <= r_ctr + 1'b1;
                        if (i_item.last) r_open <= 1'b0;
                    end else if (o_take && !i_item.is_sample) begin
                        r_state <= i_item.fast ? S_MUL : S_LOST;
                    end
                end
                S_MUL:   r_state <= S_QST;
                S_QST:   r_state <= S_QDIV;
                S_QDIV:  if (w_done) r_state <= S_CORD;
                S_CORD:  if (r_it == 5'(NSTEPS - 1)) r_state <= S_LOST;
                S_LOST:  r_state <= S_LODIV;
                S_LODIV: begin
                    if (w_done) begin
                        r_first <= w_sat;
                        r_state <= S_HIST;
                    end
                end
                S_HIST:  r_state <= S_HIDIV;
                S_HIDIV: begin
                    if (w_done) begin
                        r_last  <= w_sat;
                        r_ctr   <= '0;
                        r_min   <= RANGE_NONE;
                        r_open  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_take && !i_item.is_sample) begin
            r_v    <= i_item.speed;
            r_prod <= $signed({1'b0, i_cfg.gain}) * i_item.turn;
            r_z    <= $signed(HALF_DEFAULT);
        end
        if (r_state == S_MUL) r_num <= w_num_full[DIVN_W-1:0];
        if (r_state == S_QDIV && w_done) begin
            r_xa <= CORD_W'(200) <<< 20;
            r_ya <= $signed({w_y[33:0], 20'd0});
            r_z  <= '0;
            r_it <= '0;
        end
        if (r_state == S_CORD) begin
            r_it <= r_it + 1'b1;
            if (!r_ya[CORD_W-1]) begin
                r_xa <= r_xa + w_dx;
                r_ya <= r_ya - w_dy;
                r_z  <= r_z + w_at;
            end else begin
                r_xa <= r_xa - w_dx;
                r_ya <= r_ya + w_dy;
                r_z  <= r_z - w_at;
            end
        end
    end

endmodule

FILE: src/laser_window_collision_stop.sv
// ----------------------------------------------------------------------------
// laser_window_collision_stop
// Collision stop from a laser scan: window from odometry, running minimum.
// ----------------------------------------------------------------------------
// A scan result is written into the result queue as the back end takes the last beam.
// Throughput: one range sample per cycle while no begin holds the back end; a last
//   sample also waits for room in the result queue. A begin runs two index divides,
//   above 10 mm/s after multiply, divide and CORDIC; the item queue fills and full rises.
// The shared one-bit-per-cycle divider sets the begin time.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
module laser_window_collision_stop
#(
    parameter int MAX_BEAMS    = lwcs_pkg::MAX_BEAMS_DEF,
    parameter int CORDIC_STEPS = lwcs_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item queue in
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [15:0] i_forward_speed,
    input  logic [15:0] i_turn_rate,
    input  logic [15:0] i_range_mm,
    input  logic        i_range_invalid,
    input  logic        i_last_beam,
    // result queue out
    output logic        empty,
    input  logic        pop,
    output logic        o_stop_request,
    output logic [15:0] o_window_min_range,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data
);
    import lwcs_pkg::*;

    t_cfg       r_cfg;
    t_item      w_item;
    t_result    w_res;
    t_result    r_oq [2];
    logic       w_avail, w_take, w_res_valid, w_res_ready;
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       w_opop;

    // configuration registers: the user writes them only while idle; the block does not enforce it
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain        <= 16'd0;
            r_cfg.stop_dist   <= 16'd500;
            r_cfg.first_angle <= -23'sd2094395;
            r_cfg.step        <= 16'd6136;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN:  r_cfg.gain        <= i_cfg_data[15:0];
                REG_STOP:  r_cfg.stop_dist   <= i_cfg_data[15:0];
                REG_FIRST: r_cfg.first_angle <= $signed(i_cfg_data);
                REG_STEP:  r_cfg.step        <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify into a short queue
    lwcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_cmd     (i_cmd),
        .i_speed   ($signed(i_forward_speed)),
        .i_turn    ($signed(i_turn_rate)),
        .i_range   (i_range_mm),
        .i_invalid (i_range_invalid),
        .i_last    (i_last_beam),
        .o_full    (full),
        .o_avail   (w_avail),
        .o_item    (w_item),
        .i_take    (w_take)
    );

    // back: window setup and minimum tracking
    lwcs_back #(
        .MAX_BEAMS    (MAX_BEAMS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_avail     (w_avail),
        .i_item      (w_item),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // two entry result queue: back end keeps going while a result waits
    assign w_res_ready = (r_ocnt != 2'd2);
    assign empty       = (r_ocnt == 2'd0);
    assign w_opop      = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_res_valid) r_owp <= ~r_owp;
            if (w_opop)      r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_res_valid} - {1'b0, w_opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) r_oq[r_owp] <= w_res;
    end

    assign o_stop_request     = r_oq[r_orp].stop;
    assign o_window_min_range = r_oq[r_orp].min_range;

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (r_ocnt != 2'd2))
        else $error("result written into a full queue");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_opop && r_ocnt == 2'd1 && !w_res_valid) |=> empty)
        else $error("result queue not empty after last transfer");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop && !w_res_valid) |=> $stable(r_ocnt))
        else $error("result count moved without a transfer");

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_avail)
        else $error("back end took from an empty item queue");

endmodule

FILE: dv/laser_window_collision_stop_checker.sv
// ----------------------------------------------------------------------------
// laser_window_collision_stop_checker
// Watches the item, result and register channels, predicts each scan result
// from the transfers and compares the block's results in order.
// ----------------------------------------------------------------------------
module laser_window_collision_stop_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_cmd,
    input  logic [15:0] i_forward_speed,
    input  logic [15:0] i_turn_rate,
    input  logic [15:0] i_range_mm,
    input  logic        i_range_invalid,
    input  logic        i_last_beam,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_stop_request,
    input  logic [15:0] i_window_min_range,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lwcs_pkg::*;

    localparam int ATAN_TAB_LEN = 24;
    localparam longint ATAN_TAB [ATAN_TAB_LEN] = '{
        785398, 463648, 244979, 124355, 62419, 31240, 15624, 7812,
        3906, 1953, 977, 488, 244, 122, 61, 31,
        15, 8, 4, 2, 1, 0, 0, 0
    };

    // register copies
    longint gain, stop_dist, first_angle, step;
    // scan state
    longint beam_cnt, win_first, win_last, run_min;
    bit     scan_open;

    t_result scan_results_q[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = scan_results_q.size();

    // vectoring CORDIC on (200, reach), 2^20 scale, floor shifts
    function automatic longint half_angle_urad(input longint reach);
        longint xa, ya, z, dx, dy;
        xa = longint'(200) * 1048576;
        ya = reach * 1048576;
        z  = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_TAB_LEN; i++) begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (ya >= 0) begin
                xa = xa + dx;
                ya = ya - dy;
                z  = z + ATAN_TAB[i];
            end else begin
                xa = xa - dx;
                ya = ya + dy;
                z  = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint beam_index(input longint edge_angle);
        longint q, s;
        s = (step == 0) ? 1 : step;
        q = (edge_angle - first_angle) / s;
        if (q < -4096) q = -4096;
        if (q > 4095)  q = 4095;
        return q;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
        fails++;
    endtask

    task automatic predict_item();
        longint v, w, q, half;
        t_result r;
        if (!i_cmd) begin
            v = longint'($signed(i_forward_speed));
            w = longint'($signed(i_turn_rate));
            if (v > 10) begin
                q    = (gain * w * 1000) / (256 * v);
                half = half_angle_urad(200 + q);
            end else begin
                half = 785398;
            end
            win_first = beam_index(-half);
            win_last  = beam_index(half);
            beam_cnt  = 0;
            run_min   = 65535;
            scan_open = 1;
        end else if (scan_open) begin
            if (beam_cnt < MAX_BEAMS_DEF) begin
                if (!i_range_invalid && beam_cnt >= win_first && beam_cnt <= win_last
                    && longint'(i_range_mm) < run_min)
                    run_min = i_range_mm;
                beam_cnt++;
            end
            if (i_last_beam) begin
                r.stop      = (run_min < stop_dist);
                r.min_range = run_min[15:0];
                scan_results_q.push_back(r);
                scan_open = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            gain        = 0;
            stop_dist   = 500;
            first_angle = -2094395;
            step        = 6136;
            beam_cnt    = 0;
            win_first   = 0;
            win_last    = 0;
            run_min     = 65535;
            scan_open   = 0;
            scan_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_GAIN:  gain        = i_cfg_data[15:0];
                    REG_STOP:  stop_dist   = i_cfg_data[15:0];
                    REG_FIRST: first_angle = longint'($signed(i_cfg_data));
                    REG_STEP:  step        = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                predict_item();
            if (i_pop && !i_empty) begin
                if (scan_results_q.size() == 0) begin
                    report_mismatch("results waiting", 0, 1);
                end else begin
                    want = scan_results_q.pop_front();
                    if (i_stop_request !== want.stop)
                        report_mismatch("stop_request", want.stop, i_stop_request);
                    if (i_window_min_range !== want.min_range)
                        report_mismatch("window_min_range", want.min_range,
                                        i_window_min_range);
                end
            end
        end
    end

endmodule

FILE: dv/laser_window_collision_stop_tb.sv
// ----------------------------------------------------------------------------
// laser_window_collision_stop_tb
// Drives scans (begin with odometry, then range samples) through the block
// over several register settings, with random idling on both sides, a long
// result hold-off and a drain pause; the checker scores every result.
// ----------------------------------------------------------------------------
module laser_window_collision_stop_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lwcs_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 300;   // covers the slowest begin (divides + CORDIC)
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 1000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic        i_cmd = 0;
    logic [15:0] i_forward_speed = 0;
    logic [15:0] i_turn_rate = 0;
    logic [15:0] i_range_mm = 0;
    logic        i_range_invalid = 0;
    logic        i_last_beam = 0;
    logic        empty;
    logic        pop = 0;
    logic        o_stop_request;
    logic [15:0] o_window_min_range;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [22:0] i_cfg_data = 0;

    int fail_count;
    int pending;
    int cycles;
    int items_sent;      // items that do work (ignored samples not counted)
    bit gaps_on = 1;     // random idling, off for the last part
    bit hold_req;        // asks the receiver for one long hold-off
    bit hold_done;
    bit scan_live;       // tb view: a scan is open

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    laser_window_collision_stop u_top (
        .i_clk, .i_rst_n, .push, .full, .i_cmd, .i_forward_speed, .i_turn_rate,
        .i_range_mm, .i_range_invalid, .i_last_beam, .empty, .pop,
        .o_stop_request, .o_window_min_range, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data
    );

    laser_window_collision_stop_checker u_checker (
        .i_clk, .i_rst_n,
        .i_push(push), .i_full(full), .i_cmd, .i_forward_speed, .i_turn_rate,
        .i_range_mm, .i_range_invalid, .i_last_beam,
        .i_empty(empty), .i_pop(pop), .i_stop_request(o_stop_request),
        .i_window_min_range(o_window_min_range),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random pops, one long hold-off on request
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                pop <= 0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                pop <= 0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                pop <= 1;
                @(posedge i_clk);
            end
        end
    end

    // one item transfer; full is read at the falling edge where it is stable
    task automatic put_item(input bit cmd, input logic [15:0] spd, input logic [15:0] turn,
                            input logic [15:0] rng, input bit inv, input bit last);
        push            <= 1;
        i_cmd           <= cmd;
        i_forward_speed <= spd;
        i_turn_rate     <= turn;
        i_range_mm      <= rng;
        i_range_invalid <= inv;
        i_last_beam     <= last;
        @(negedge i_clk);
        while (full) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        if (!cmd) begin
            scan_live = 1;
            items_sent++;
        end else if (scan_live) begin
            items_sent++;
            if (last) scan_live = 0;
        end
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // begin item; unused sample fields get random junk
    task automatic open_scan(input logic [15:0] spd, input logic [15:0] turn);
        put_item(0, spd, turn, 16'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic put_sample(input logic [15:0] rng, input bit inv, input bit last);
        put_item(1, 16'($urandom), 16'($urandom), rng, inv, last);
    endtask

    task automatic drain();
        push <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; set_config drops it
    task automatic cfg_write(input logic [1:0] idx, input logic [22:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // all four registers, only once the block is idle
    task automatic set_config(input int gain, input int stop_d, input int first, input int step);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        cfg_write(REG_GAIN, 23'(gain));
        cfg_write(REG_STOP, 23'(stop_d));
        cfg_write(REG_FIRST, 23'(first));
        cfg_write(REG_STEP, 23'(step));
        i_cfg_valid <= 0;
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 21) - 11);
            1:       return 16'($urandom);
            2:       return 16'($urandom_range(11, 300));
            default: return 16'($urandom_range(11, 32767));
        endcase
    endfunction

    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 1000));
            default: return 16'($urandom_range(0, 8000));
        endcase
    endfunction

    task automatic full_scan(input int beams);
        open_scan(pick_speed(), 16'($urandom));
        for (int b = 0; b < beams; b++)
            put_sample(pick_range(), $urandom_range(0, 4) == 0, b == beams - 1);
    endtask

    initial begin
        int limit;
        int gain, stop_d, first, step;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: window at beams 0..39 under the default odometry
        set_config(0, 500, -800000, 40000);
        open_scan(16'd0, 16'd0);                // slow: 45 degree half-angle window
        put_sample(16'd0, 1, 0);                // invalid zero is skipped
        put_sample(16'd100, 0, 0);
        put_sample(16'hFFFF, 0, 0);
        put_sample(16'd700, 0, 1);              // stop expected
        put_sample(16'd5, 0, 1);                // no open scan: ignored
        open_scan(16'h7FFF, 16'h7FFF);
        put_sample(16'd3000, 0, 1);
        open_scan(16'h8000, 16'h8000);          // negative speed: default window
        put_sample(16'd10, 0, 0);
        open_scan(16'd11, 16'h8000);            // begin drops the open scan
        put_sample(16'd20, 0, 1);
        set_config(65535, 65535, -3141593, 1);
        open_scan(16'd11, 16'h8000);            // negative reach: empty window
        put_sample(16'd0, 0, 0);
        put_sample(16'd1, 0, 1);
        open_scan(16'd11, 16'h7FFF);
        put_sample(16'd0, 0, 0);
        put_sample(16'hFFFF, 0, 1);
        set_config(256, 0, 3141593, 0);         // zero step acts as one
        open_scan(16'd12, 16'd1);
        put_sample(16'd0, 0, 1);

        // random phases
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin gain = 65535; stop_d = 65535; first = -3141593; step = 65535; end
                1: begin gain = 0;     stop_d = 0;     first = 3141593;  step = 1;     end
                2: begin gain = 0;     stop_d = 500;   first = -2094395; step = 6136;  end
                default: begin
                    gain   = $urandom_range(0, 65535);
                    stop_d = $urandom_range(0, 65535);
                    step   = $urandom_range(1, 65535);
                    first  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6283186) - 3141593
                                                         : -$urandom_range(100000, 1600000);
                end
            endcase
            if (p == PHASES - 2) gaps_on = 0;
            set_config(gain, stop_d, first, step);
            if (p == 2) full_scan(1100);        // runs past MAX_BEAMS
            limit = items_sent + PHASE_ITEMS;
            // the hold-off phase keeps offering items until the receiver resumes
            while (items_sent < limit || (p == 4 && hold_req && !hold_done)) begin
                if (p == 4 && !hold_req) hold_req = 1;
                if (p == 5 && items_sent > limit - PHASE_ITEMS / 2 && !hold_done) begin
                    hold_done = 1;
                end
                if (p == 6 && items_sent > limit - PHASE_ITEMS / 2 && scan_live == 0
                    && $urandom_range(0, 9) == 0)
                    drain();                    // sender pause until all results are in
                case ($urandom_range(0, 19))
                    0: put_sample(pick_range(), 1'($urandom), 1'($urandom)); // stray
                    1: begin                    // broken scan, dropped by a new begin
                        open_scan(pick_speed(), 16'($urandom));
                        repeat ($urandom_range(0, 8))
                            put_sample(pick_range(), 1'($urandom), 0);
                    end
                    default: full_scan($urandom_range(1, 64));
                endcase
            end
            if (scan_live) put_sample(pick_range(), 0, 1);
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/lwcs_pkg.sv
src/lwcs_div.sv
src/lwcs_front.sv
src/lwcs_back.sv
src/laser_window_collision_stop.sv
dv/laser_window_collision_stop_checker.sv
dv/laser_window_collision_stop_tb.sv
